// ===== hw/rtl/terminal_key_event_decoder_core_defines.svh =====
// assertion macros for the terminal key event decoder
`ifndef TERMINAL_KEY_EVENT_DECODER_CORE_DEFINES_SVH
`define TERMINAL_KEY_EVENT_DECODER_CORE_DEFINES_SVH

// clocked assertion with explicit clock and active-low reset
`define TKED_ASSERT_CR(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion on the default clk_i / rst_ni pair
`define TKED_ASSERT(label, prop, msg) \
  `TKED_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/tked_pkg.sv =====
// shared types and constants of the terminal key event decoder
`default_nettype none

package tked_pkg;

  typedef enum logic [4:0] {
    EvNone      = 5'd0,
    EvQuit      = 5'd1,
    EvSelect    = 5'd2,
    EvPrefix    = 5'd3,
    EvUndo      = 5'd4,
    EvRedo      = 5'd5,
    EvBackspace = 5'd6,
    EvNewline   = 5'd7,
    EvEscape    = 5'd8,
    EvUp        = 5'd9,
    EvDown      = 5'd10,
    EvRight     = 5'd11,
    EvLeft      = 5'd12,
    EvHome      = 5'd13,
    EvEnd       = 5'd14,
    EvDelete    = 5'd15,
    EvChar      = 5'd16
  } tked_event_e;

  localparam logic [7:0] TimeoutReset = 8'd50;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } tked_item_t;

  typedef struct packed {
    tked_event_e event_kind;
    logic [31:0] text_bytes;
    logic [2:0]  text_length;
  } tked_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tked_intf.sv =====
// valid/ready channel interfaces of the terminal key event decoder
`default_nettype none

interface tked_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink (input valid, input operation, input byte_value, output ready);
endinterface

interface tked_result_if;
  logic        valid;
  logic        ready;
  logic [4:0]  event_kind;
  logic [31:0] text_bytes;
  logic [2:0]  text_length;

  modport source (output valid, output event_kind, output text_bytes, output text_length,
                  input ready);
  modport sink (input valid, input event_kind, input text_bytes, input text_length,
                output ready);
endinterface

interface tked_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] escape_timeout_ticks;

  modport source (output valid, output escape_timeout_ticks, input ready);
  modport sink (input valid, input escape_timeout_ticks, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tked_in_reg.sv =====
// input register stage holding one accepted beat
`default_nettype none

module tked_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  tked_pkg::tked_item_t item_i,
  input  wire                 advance_i,
  output logic                valid_o,
  output tked_pkg::tked_item_t item_o
);
  import tked_pkg::*;

  logic       valid_q, valid_d;
  tked_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = valid_i ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ready_o ? valid_d : valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tked_parser.sv =====
// parse state and single-pass decode of one byte or tick
`default_nettype none

module tked_parser #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  tked_pkg::tked_item_t   item_i,
  input  wire [15:0]            timeout_i,
  output logic                  has_result_o,
  output tked_pkg::tked_result_t result_o
);
  import tked_pkg::*;

  localparam int unsigned Nb = TICK_COUNTER_BITS;
  localparam logic [31:0] CntMax = 32'((64'd1 << TICK_COUNTER_BITS) - 64'd1);

  localparam logic [7:0] ByteEsc       = 8'd27;
  localparam logic [7:0] ByteLbracket  = 8'h5B;
  localparam logic [7:0] ByteSemicolon = 8'h3B;
  localparam logic [7:0] ByteO         = 8'h4F;
  localparam logic [7:0] ByteTilde     = 8'h7E;
  localparam logic [7:0] ByteZero      = 8'h30;
  localparam logic [7:0] ByteNine      = 8'h39;
  localparam logic [7:0] ByteOne       = 8'h31;
  localparam logic [7:0] ByteThree     = 8'h33;
  localparam logic [7:0] ByteFour      = 8'h34;
  localparam logic [7:0] ByteSeven     = 8'h37;
  localparam logic [7:0] ByteEight     = 8'h38;
  localparam logic [7:0] ByteSpace     = 8'd32;
  localparam logic [7:0] ByteDel       = 8'd127;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhUtf8 = 4'b0010,
    PhEsc  = 4'b0100,
    PhSeq  = 4'b1000
  } tked_phase_e;

  function automatic logic is_param(input logic [7:0] b);
    is_param = (b == ByteLbracket) || (b == ByteSemicolon) || (b >= ByteZero && b <= ByteNine);
  endfunction

  function automatic tked_event_e letter_kind(input logic [7:0] b);
    unique case (b)
      8'h41:   letter_kind = EvUp;
      8'h42:   letter_kind = EvDown;
      8'h43:   letter_kind = EvRight;
      8'h44:   letter_kind = EvLeft;
      8'h48:   letter_kind = EvHome;
      8'h46:   letter_kind = EvEnd;
      default: letter_kind = EvNone;
    endcase
  endfunction

  function automatic tked_event_e single_byte(input logic [7:0] b);
    unique case (b)
      8'd17:        single_byte = EvQuit;
      8'd19:        single_byte = EvSelect;
      8'd11:        single_byte = EvPrefix;
      8'd21:        single_byte = EvUndo;
      8'd25:        single_byte = EvRedo;
      8'd127, 8'd8: single_byte = EvBackspace;
      8'd13, 8'd10: single_byte = EvNewline;
      default:      single_byte = EvNone;
    endcase
  endfunction

  function automatic tked_event_e decode_final(input logic [7:0] fin, input logic [7:0] first,
                                               input logic [7:0] second, input logic [1:0] cnt);
    tked_event_e k;
    k = EvNone;
    if (first != ByteLbracket && first != ByteO) begin
      k = EvNone;
    end else if (cnt <= 2'd1) begin
      k = letter_kind(fin);
    end else if (first != ByteLbracket) begin
      k = EvNone;
    end else if (fin == ByteTilde) begin
      if (second == ByteThree) begin
        k = EvDelete;
      end else if (second == ByteOne || second == ByteSeven) begin
        k = EvHome;
      end else if (second == ByteFour || second == ByteEight) begin
        k = EvEnd;
      end else begin
        k = EvNone;
      end
    end else begin
      k = letter_kind(fin);
    end
    return k;
  endfunction

  tked_phase_e     phase_q, phase_d;
  logic [Nb-1:0]   tick_q, tick_d, tick_inc;
  logic [1:0]      pcount_q, pcount_d;
  logic [7:0]      first_q, first_d, second_q, second_d;
  logic [31:0]     ubuf_q, ubuf_d;
  logic [2:0]      uexp_q, uexp_d, urcv_q, urcv_d;
  logic [31:0]     limit;
  logic [7:0]      b;

  assign b        = item_i.byte_value;
  assign tick_inc = (tick_q != {Nb{1'b1}}) ? tick_q + Nb'(1) : tick_q;

  always_comb begin
    limit = (timeout_i == 16'd0) ? 32'd1 : 32'(timeout_i);
    if (limit > CntMax) begin
      limit = CntMax;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    pcount_d     = pcount_q;
    first_d      = first_q;
    second_d     = second_q;
    ubuf_d       = ubuf_q;
    uexp_d       = uexp_q;
    urcv_d       = urcv_q;
    has_result_o = 1'b0;
    result_o     = '{event_kind: EvNone, text_bytes: 32'd0, text_length: 3'd0};
    if (item_i.operation) begin
      if (phase_q == PhEsc || phase_q == PhSeq) begin
        tick_d = tick_inc;
        if (32'(tick_inc) >= limit) begin
          phase_d             = PhIdle;
          tick_d              = '0;
          has_result_o        = 1'b1;
          result_o.event_kind = (phase_q == PhEsc) ? EvEscape : EvNone;
        end
      end
    end else begin
      unique case (phase_q)
        PhUtf8: begin
          if (b[7:6] != 2'b10) begin
            phase_d      = PhIdle;
            has_result_o = 1'b1;
          end else begin
            ubuf_d = ubuf_q | (32'(b) << {urcv_q[1:0], 3'b000});
            urcv_d = urcv_q + 3'd1;
            if (urcv_d >= uexp_q) begin
              phase_d              = PhIdle;
              has_result_o         = 1'b1;
              result_o.event_kind  = EvChar;
              result_o.text_bytes  = ubuf_d;
              result_o.text_length = uexp_q;
            end
          end
        end
        PhEsc: begin
          tick_d = '0;
          if (b == ByteO || is_param(b)) begin
            first_d  = b;
            second_d = 8'd0;
            pcount_d = 2'd1;
            phase_d  = PhSeq;
          end else begin
            phase_d      = PhIdle;
            has_result_o = 1'b1;
          end
        end
        PhSeq: begin
          tick_d = '0;
          if (is_param(b)) begin
            if (pcount_q == 2'd1) begin
              second_d = b;
            end
            if (pcount_q != 2'd3) begin
              pcount_d = pcount_q + 2'd1;
            end
          end else begin
            phase_d             = PhIdle;
            has_result_o        = 1'b1;
            result_o.event_kind = decode_final(b, first_q, second_q, pcount_q);
          end
        end
        PhIdle: begin
          if (b == ByteEsc) begin
            phase_d  = PhEsc;
            tick_d   = '0;
            pcount_d = 2'd0;
            first_d  = 8'd0;
            second_d = 8'd0;
          end else if (single_byte(b) != EvNone) begin
            has_result_o        = 1'b1;
            result_o.event_kind = single_byte(b);
          end else if (b >= ByteSpace && b < ByteDel) begin
            has_result_o         = 1'b1;
            result_o.event_kind  = EvChar;
            result_o.text_bytes  = 32'(b);
            result_o.text_length = 3'd1;
          end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            priority if (b[7:5] == 3'b110) begin
              uexp_d = 3'd2;
            end else if (b[7:4] == 4'b1110) begin
              uexp_d = 3'd3;
            end else begin
              uexp_d = 3'd4;
            end
            ubuf_d  = 32'(b);
            urcv_d  = 3'd1;
            phase_d = PhUtf8;
          end else begin
            has_result_o = 1'b1;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      tick_q   <= '0;
      pcount_q <= 2'd0;
      first_q  <= 8'd0;
      second_q <= 8'd0;
      ubuf_q   <= 32'd0;
      uexp_q   <= 3'd0;
      urcv_q   <= 3'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      pcount_q <= pcount_d;
      first_q  <= first_d;
      second_q <= second_d;
      ubuf_q   <= ubuf_d;
      uexp_q   <= uexp_d;
      urcv_q   <= urcv_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tked_out_reg.sv =====
// result register holding one event beat until taken
`default_nettype none

module tked_out_reg (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  tked_pkg::tked_result_t  result_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire                    ready_i,
  output tked_pkg::tked_result_t  result_o
);
  import tked_pkg::*;

  logic         valid_q;
  tked_result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/terminal_key_event_decoder_core.sv =====
// top level of the terminal key event decoder
//
//   channel   dir  payload                                   beat when
//   item_i    in   operation, byte_value                     valid && ready
//   result_o  out  event_kind, text_bytes, text_length       valid && ready
//   cfg_i     in   escape_timeout_ticks                      valid && ready
//
// one beat per cycle unless the result is stalled; an input beat reaches its event via
// the input register, then the parser into the result register
// items that give no event are consumed without touching the result register
// reset clears all parse state and sets the timeout to 50 ticks
// item_i.ready drops only while the input register is full and the result is stalled
`default_nettype none

`include "terminal_key_event_decoder_core_defines.svh"

module terminal_key_event_decoder_core #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  tked_item_if.sink      item_i,
  tked_result_if.source  result_o,
  tked_cfg_if.sink       cfg_i
);
  import tked_pkg::*;

  logic [15:0]  timeout_q;
  tked_item_t   in_item, stage_item;
  logic         stage_valid, out_free, advance, has_result;
  tked_result_t parsed, held;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'(TimeoutReset);
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.escape_timeout_ticks;
    end
  end

  assign in_item = '{operation: item_i.operation, byte_value: item_i.byte_value};
  assign advance = stage_valid && out_free;

  tked_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_i.valid),
    .ready_o   (item_i.ready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  tked_parser #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (stage_item),
    .timeout_i    (timeout_q),
    .has_result_o (has_result),
    .result_o     (parsed)
  );

  tked_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && has_result),
    .result_i (parsed),
    .free_o   (out_free),
    .valid_o  (result_o.valid),
    .ready_i  (result_o.ready),
    .result_o (held)
  );

  assign result_o.event_kind  = 5'(held.event_kind);
  assign result_o.text_bytes  = held.text_bytes;
  assign result_o.text_length = held.text_length;

  `TKED_ASSERT(a_char_len, (result_o.valid && result_o.event_kind == EvChar) |-> (result_o.text_length != 3'd0 && result_o.text_length <= 3'd4), "char event with bad length")
  `TKED_ASSERT(a_no_text, (result_o.valid && result_o.event_kind != EvChar) |-> (result_o.text_length == 3'd0 && result_o.text_bytes == 32'd0), "text on non-char event")
  `TKED_ASSERT(a_stall_cause, !item_i.ready |-> (stage_valid && result_o.valid && !result_o.ready), "input stalled without a full pipe")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench of the terminal key event decoder: directed and random key streams vs a local decoder
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import tked_pkg::*;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [7:0] ByteQuit   = 8'd17;
  localparam logic [7:0] ByteSelect = 8'd19;
  localparam logic [7:0] BytePrefix = 8'd11;
  localparam logic [7:0] ByteUndo   = 8'd21;
  localparam logic [7:0] ByteRedo   = 8'd25;
  localparam logic [7:0] ByteDel    = 8'd127;
  localparam logic [7:0] ByteBs     = 8'd8;
  localparam logic [7:0] ByteCr     = 8'd13;
  localparam logic [7:0] ByteLf     = 8'd10;
  localparam logic [7:0] ByteEsc    = 8'd27;

  localparam int unsigned TickMax       = 65535;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 5;
  localparam int unsigned WatchdogLimit = 2000;

  typedef enum logic [1:0] {
    PhIdle,
    PhUtf8,
    PhEsc,
    PhSeq
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tked_item_if   item_bus ();
  tked_result_if result_bus ();
  tked_cfg_if    cfg_bus ();

  terminal_key_event_decoder_core #(
    .TICK_COUNTER_BITS(16)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // decoder state mirrored by the testbench
  parse_phase_e dec_phase;
  logic [15:0]  dec_ticks;
  logic [1:0]   dec_params;
  logic [7:0]   dec_intro;
  logic [7:0]   dec_second;
  logic [31:0]  u8_buf;
  logic [2:0]   u8_need;
  logic [2:0]   u8_have;
  logic [15:0]  dec_timeout;

  tked_result_t pending_events[$];
  tked_result_t event_want;

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  logic        hold_off_req;
  logic        idling_on;

  function automatic logic is_seq_param(logic [7:0] b);
    return b == "[" || b == ";" || (b >= "0" && b <= "9");
  endfunction

  function automatic tked_event_e letter_event(logic [7:0] b);
    case (b)
      "A": return EvUp;
      "B": return EvDown;
      "C": return EvRight;
      "D": return EvLeft;
      "H": return EvHome;
      "F": return EvEnd;
      default: return EvNone;
    endcase
  endfunction

  function automatic tked_event_e control_event(logic [7:0] b);
    case (b)
      ByteQuit: return EvQuit;
      ByteSelect: return EvSelect;
      BytePrefix: return EvPrefix;
      ByteUndo: return EvUndo;
      ByteRedo: return EvRedo;
      ByteDel, ByteBs: return EvBackspace;
      ByteCr, ByteLf: return EvNewline;
      default: return EvNone;
    endcase
  endfunction

  function automatic tked_event_e sequence_event(logic [7:0] fin);
    if (dec_intro != "[" && dec_intro != "O") return EvNone;
    if (dec_params <= 2'd1) return letter_event(fin);
    if (dec_intro != "[") return EvNone;
    if (fin == "~") begin
      case (dec_second)
        "3": return EvDelete;
        "1", "7": return EvHome;
        "4", "8": return EvEnd;
        default: return EvNone;
      endcase
    end
    return letter_event(fin);
  endfunction

  function automatic void predict_key_item(logic op, logic [7:0] b);
    tked_result_t ev;
    logic         fire;
    int unsigned  lim;
    ev = '{EvNone, 32'd0, 3'd0};
    fire = 1'b0;
    if (op == OpTick) begin
      if (dec_phase == PhEsc || dec_phase == PhSeq) begin
        lim = (dec_timeout == 16'd0) ? 1 : int'(dec_timeout);
        if (dec_ticks != 16'(TickMax)) dec_ticks = dec_ticks + 16'd1;
        if (int'(dec_ticks) >= lim) begin
          ev.event_kind = (dec_phase == PhEsc) ? EvEscape : EvNone;
          dec_phase = PhIdle;
          dec_ticks = 16'd0;
          fire = 1'b1;
        end
      end
    end else begin
      case (dec_phase)
        PhUtf8: begin
          if (b[7:6] != 2'b10) begin
            dec_phase = PhIdle;
            fire = 1'b1;
          end else begin
            u8_buf = u8_buf | (32'(b) << (8 * u8_have[1:0]));
            u8_have = u8_have + 3'd1;
            if (u8_have >= u8_need) begin
              dec_phase = PhIdle;
              fire = 1'b1;
              ev = '{EvChar, u8_buf, u8_need};
            end
          end
        end
        PhEsc: begin
          dec_ticks = 16'd0;
          if (b == "O" || is_seq_param(b)) begin
            dec_intro = b;
            dec_second = 8'd0;
            dec_params = 2'd1;
            dec_phase = PhSeq;
          end else begin
            dec_phase = PhIdle;
            fire = 1'b1;
          end
        end
        PhSeq: begin
          dec_ticks = 16'd0;
          if (is_seq_param(b)) begin
            if (dec_params == 2'd1) dec_second = b;
            if (dec_params != 2'd3) dec_params = dec_params + 2'd1;
          end else begin
            dec_phase = PhIdle;
            fire = 1'b1;
            ev.event_kind = sequence_event(b);
          end
        end
        default: begin
          if (b == ByteEsc) begin
            dec_phase = PhEsc;
            dec_ticks = 16'd0;
            dec_params = 2'd0;
            dec_intro = 8'd0;
            dec_second = 8'd0;
          end else if (control_event(b) != EvNone) begin
            fire = 1'b1;
            ev.event_kind = control_event(b);
          end else if (b >= 8'd32 && b < 8'd127) begin
            fire = 1'b1;
            ev = '{EvChar, 32'(b), 3'd1};
          end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            u8_need = (b[7:5] == 3'b110) ? 3'd2 : (b[7:4] == 4'b1110) ? 3'd3 : 3'd4;
            u8_buf = 32'(b);
            u8_have = 3'd1;
            dec_phase = PhUtf8;
          end else begin
            fire = 1'b1;
          end
        end
      endcase
    end
    if (fire) pending_events.insert(pending_events.size(), ev);
  endfunction

  task automatic send_key_item(logic op, logic [7:0] b);
    while (idling_on && $urandom_range(0, 99) < 13) begin
      item_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.operation <= op;
    item_bus.byte_value <= b;
    do @(posedge clk_i); while (!item_bus.ready);
    predict_key_item(op, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_key_item(OpByte, b);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_key_item(OpTick, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_events_drained();
    item_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_escape_timeout(logic [15:0] v);
    wait_events_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.escape_timeout_ticks <= v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    dec_timeout = v;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // random picks
  function automatic logic [7:0] pick_control();
    case ($urandom_range(0, 8))
      0: return ByteQuit;
      1: return ByteSelect;
      2: return BytePrefix;
      3: return ByteUndo;
      4: return ByteRedo;
      5: return ByteDel;
      6: return ByteBs;
      7: return ByteCr;
      default: return ByteLf;
    endcase
  endfunction

  function automatic logic [7:0] pick_param();
    int unsigned idx;
    idx = $urandom_range(0, 11);
    if (idx == 10) return ";";
    if (idx == 11) return "[";
    return "0" + 8'(idx);
  endfunction

  function automatic logic [7:0] pick_final();
    case ($urandom_range(0, 9))
      0: return "A";
      1: return "B";
      2: return "C";
      3: return "D";
      4: return "H";
      5: return "F";
      6, 7: return "~";
      8: return ByteEsc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] utf8_lead(int unsigned n);
    if (n == 2) return 8'hC0 | 8'($urandom_range(0, 31));
    if (n == 3) return 8'hE0 | 8'($urandom_range(0, 15));
    return 8'hF0 | 8'($urandom_range(0, 7));
  endfunction

  function automatic int unsigned tick_span();
    return (dec_timeout > 16'd20) ? 21 : int'(dec_timeout) + 1;
  endfunction

  task automatic send_random_burst();
    int unsigned r;
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_byte(pick_control());
    end else if (r < 28) begin
      send_byte(8'($urandom_range(32, 126)));
    end else if (r < 43) begin
      n = $urandom_range(2, 4);
      send_byte(utf8_lead(n));
      for (k = 1; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) send_ticks(1);
        send_byte(8'h80 | 8'($urandom_range(0, 63)));
      end
    end else if (r < 48) begin
      n = $urandom_range(2, 4);
      send_byte(utf8_lead(n));
      repeat ($urandom_range(0, n - 2)) send_byte(8'h80 | 8'($urandom_range(0, 63)));
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      send_byte(b);
    end else if (r < 75) begin
      send_byte(ByteEsc);
      case ($urandom_range(0, 9))
        0: send_byte(pick_param());
        1, 2, 3: send_byte("O");
        default: send_byte("[");
      endcase
      n = $urandom_range(0, 4);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 4) == 0) send_ticks($urandom_range(0, tick_span()));
        send_byte(pick_param());
      end
      if ($urandom_range(0, 9) == 0) send_ticks(tick_span());
      else send_byte(pick_final());
    end else if (r < 85) begin
      send_byte(ByteEsc);
      send_ticks($urandom_range(0, tick_span()));
      if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)));
    end else if (r < 95) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_ticks(1);
    end
  endtask

  task automatic test_control_and_text();
    send_byte(ByteQuit);
    send_byte(ByteSelect);
    send_byte(BytePrefix);
    send_byte(ByteUndo);
    send_byte(ByteRedo);
    send_byte(ByteDel);
    send_byte(ByteBs);
    send_byte(ByteCr);
    send_byte(ByteLf);
    send_byte(8'h00);
    send_byte(8'h20);
    send_byte(8'h7E);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_key_item(OpTick, 8'hFF);
  endtask

  task automatic test_utf8_gather();
    send_byte(8'hC3);
    send_byte(8'hA9);
    send_byte(8'hE2);
    send_key_item(OpTick, 8'h00);
    send_byte(8'h82);
    send_byte(8'hAC);
    send_byte(8'hF0);
    send_byte(8'h9F);
    send_byte(8'h98);
    send_byte(8'h80);
    send_byte(8'hC3);
    send_byte("A");
  endtask

  task automatic test_escape_decode();
    send_byte(ByteEsc); send_byte("["); send_byte("A");
    send_byte(ByteEsc); send_byte("O"); send_byte("H");
    send_byte(ByteEsc); send_byte("["); send_byte("3"); send_byte("~");
    send_byte(ByteEsc); send_byte("["); send_byte("1"); send_byte(";"); send_byte("5");
    send_byte("D");
    send_byte(ByteEsc); send_byte("["); send_byte("7"); send_byte("~");
    send_byte(ByteEsc); send_byte("["); send_byte("8"); send_byte("~");
    send_byte(ByteEsc); send_byte("O"); send_byte("1"); send_byte("~");
    send_byte(ByteEsc); send_byte("x");
    send_byte(ByteEsc); send_byte("["); send_byte(ByteEsc);
    send_byte(ByteEsc); send_byte("["); send_byte("Z");
  endtask

  task automatic test_escape_timeout();
    // reset value of the timeout
    send_byte(ByteEsc);
    send_ticks(50);
    write_escape_timeout(16'd1);
    send_byte(ByteEsc);
    send_ticks(1);
    send_byte(ByteEsc);
    send_byte("[");
    send_ticks(1);
    write_escape_timeout(16'd2);
    send_byte(ByteEsc);
    send_ticks(1);
    send_byte("[");
    send_ticks(2);
    write_escape_timeout(16'hFFFF);
    send_byte(ByteEsc);
    send_ticks(40);
    send_byte("a");
    // zero timeout acts as one tick
    write_escape_timeout(16'd0);
    send_byte(ByteEsc);
    send_ticks(1);
  endtask

  task automatic test_backpressure();
    int unsigned k;
    write_escape_timeout(16'd4);
    @(posedge clk_i);
    hold_off_req = 1'b1;
    @(negedge clk_i);
    for (k = 0; k < 60; k++) send_byte(8'($urandom_range(32, 126)));
    wait_events_drained();
    send_byte(ByteEsc);
    send_byte("[");
    send_byte("4");
    send_byte("~");
  endtask

  task automatic test_random_traffic();
    int unsigned p;
    int unsigned goal;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: write_escape_timeout(16'd1);
        1: write_escape_timeout(16'($urandom_range(2, 6)));
        2: write_escape_timeout(16'($urandom_range(7, 20)));
        default: write_escape_timeout(16'd3);
      endcase
      idling_on = (p != 2);
      goal = items_sent + 200;
      while (items_sent < goal) send_random_burst();
    end
    idling_on = 1'b1;
  endtask

  // result sink with random stalls and a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= !(idling_on && $urandom_range(0, 99) < 13);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event beat with nothing pending: kind %0d bytes %h length %0d",
                 $time, result_bus.event_kind, result_bus.text_bytes, result_bus.text_length);
        mismatches++;
      end else begin
        event_want = pending_events.pop_front();
        if (result_bus.event_kind !== event_want.event_kind) begin
          $display("%0t: event_kind expected %0d actual %0d", $time, event_want.event_kind,
                   result_bus.event_kind);
          mismatches++;
        end
        if (result_bus.text_bytes !== event_want.text_bytes) begin
          $display("%0t: text_bytes expected %h actual %h", $time, event_want.text_bytes,
                   result_bus.text_bytes);
          mismatches++;
        end
        if (result_bus.text_length !== event_want.text_length) begin
          $display("%0t: text_length expected %0d actual %0d", $time, event_want.text_length,
                   result_bus.text_length);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.operation = OpByte;
    item_bus.byte_value = 8'd0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.escape_timeout_ticks = 16'd0;
    hold_off_req = 1'b0;
    hold_left = 0;
    idling_on = 1'b1;
    mismatches = 0;
    items_sent = 0;
    quiet_cycles = 0;
    dec_phase = PhIdle;
    dec_ticks = 16'd0;
    dec_params = 2'd0;
    dec_intro = 8'd0;
    dec_second = 8'd0;
    u8_buf = 32'd0;
    u8_need = 3'd0;
    u8_have = 3'd0;
    dec_timeout = 16'(TimeoutReset);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_control_and_text();
    test_utf8_gather();
    test_escape_decode();
    test_escape_timeout();
    test_backpressure();
    test_random_traffic();

    wait_events_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tked_pkg.sv
hw/rtl/tked_intf.sv
hw/rtl/tked_in_reg.sv
hw/rtl/tked_parser.sv
hw/rtl/tked_out_reg.sv
hw/rtl/terminal_key_event_decoder_core.sv
verif/tb_top.sv
